### rtl/stkf_pkg.sv
// Shared types, constants, saturating arithmetic and microprogram for the tracking filter.
package stkf_pkg;

   localparam int INTERNAL_WIDTH = 64;
   localparam logic [63:0] TOP_MAG = 64'd1 << (INTERNAL_WIDTH - 1);
   localparam logic [63:0] LIM_HI  = TOP_MAG - 64'd1;
   localparam logic [63:0] LIM_LO  = ~LIM_HI;

   localparam logic [63:0] ONE_Q   = 64'h0000_0001_0000_0000;
   localparam logic [63:0] Q_NOISE = 64'd429497;
   localparam logic [63:0] R_NOISE = 64'd42949673;
   localparam logic [63:0] F_02    = 64'd429067233;
   localparam logic [63:0] F_12    = 64'd42949673;
   localparam logic [63:0] TEN_Q   = 64'h0000_000A_0000_0000;
   localparam logic [63:0] INIT_X  = 64'h0000_0140_0000_0000;

   localparam logic [16:0] FORGET_RST = 17'd62259;
   localparam logic [23:0] WEAK_RST   = 24'd65536;
   localparam logic        CSR_FORGET = 1'b0;
   localparam logic        CSR_WEAK   = 1'b1;

   localparam int NREG = 48;

   localparam logic [3:0] OP_LDK  = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_SUB  = 4'd2;
   localparam logic [3:0] OP_MUL  = 4'd3;
   localparam logic [3:0] OP_DIV  = 4'd4;
   localparam logic [3:0] OP_SELS = 4'd5;
   localparam logic [3:0] OP_LAM  = 4'd6;
   localparam logic [3:0] OP_OUT  = 4'd7;
   localparam logic [3:0] OP_END  = 4'd8;

   localparam logic [5:0] K_ZERO  = 6'd0;
   localparam logic [5:0] K_ONE   = 6'd1;
   localparam logic [5:0] K_QN    = 6'd2;
   localparam logic [5:0] K_RN    = 6'd3;
   localparam logic [5:0] K_F02   = 6'd4;
   localparam logic [5:0] K_F12   = 6'd5;
   localparam logic [5:0] K_TEN   = 6'd6;
   localparam logic [5:0] K_INITX = 6'd7;
   localparam logic [5:0] K_RHO   = 6'd8;
   localparam logic [5:0] K_BETA  = 6'd9;
   localparam logic [5:0] K_Z     = 6'd10;

   localparam logic [5:0] R_ZERO = 6'd0;
   localparam logic [5:0] R_ONE  = 6'd1;
   localparam logic [5:0] R_QN   = 6'd2;
   localparam logic [5:0] R_RN   = 6'd3;
   localparam logic [5:0] R_F02  = 6'd4;
   localparam logic [5:0] R_F12  = 6'd5;
   localparam logic [5:0] R_TEN  = 6'd6;
   localparam logic [5:0] R_RHO  = 6'd7;
   localparam logic [5:0] R_BETA = 6'd8;
   localparam logic [5:0] R_X0   = 6'd9;
   localparam logic [5:0] R_X1   = 6'd10;
   localparam logic [5:0] R_X2   = 6'd11;
   localparam logic [5:0] R_P00  = 6'd12;
   localparam logic [5:0] R_P01  = 6'd13;
   localparam logic [5:0] R_P02  = 6'd14;
   localparam logic [5:0] R_P10  = 6'd15;
   localparam logic [5:0] R_P11  = 6'd16;
   localparam logic [5:0] R_P12  = 6'd17;
   localparam logic [5:0] R_P20  = 6'd18;
   localparam logic [5:0] R_P21  = 6'd19;
   localparam logic [5:0] R_P22  = 6'd20;
   localparam logic [5:0] R_S    = 6'd21;
   localparam logic [5:0] R_Z    = 6'd22;
   localparam logic [5:0] R_E    = 6'd23;
   localparam logic [5:0] R_XP0  = 6'd24;
   localparam logic [5:0] R_XP1  = 6'd25;
   localparam logic [5:0] R_FP00 = 6'd26;
   localparam logic [5:0] R_FP01 = 6'd27;
   localparam logic [5:0] R_FP02 = 6'd28;
   localparam logic [5:0] R_FP10 = 6'd29;
   localparam logic [5:0] R_FP11 = 6'd30;
   localparam logic [5:0] R_FP12 = 6'd31;
   localparam logic [5:0] R_A00  = 6'd32;
   localparam logic [5:0] R_A01  = 6'd33;
   localparam logic [5:0] R_A10  = 6'd34;
   localparam logic [5:0] R_A11  = 6'd35;
   localparam logic [5:0] R_PP00 = 6'd36;
   localparam logic [5:0] R_PP01 = 6'd37;
   localparam logic [5:0] R_PP10 = 6'd38;
   localparam logic [5:0] R_PP11 = 6'd39;
   localparam logic [5:0] R_K0   = 6'd40;
   localparam logic [5:0] R_K1   = 6'd41;
   localparam logic [5:0] R_T0   = 6'd42;
   localparam logic [5:0] R_T1   = 6'd43;
   localparam logic [5:0] R_T2   = 6'd44;
   localparam logic [5:0] R_N    = 6'd45;
   localparam logic [5:0] R_LAM  = 6'd46;
   localparam logic [5:0] R_SD   = 6'd47;

   typedef struct packed {
      logic [3:0] op;
      logic [5:0] dst;
      logic [5:0] a;
      logic [5:0] b;
   } instr_type;

   typedef struct packed {
      logic      go;
      logic      load;
      instr_type ins;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

   localparam int PROG_LEN   = 109;
   localparam int ITEM_START = 14;
   localparam int PC_W       = $clog2(PROG_LEN);

   localparam instr_type PROG [PROG_LEN] = '{
      // reset program
      '{OP_LDK, R_X0,  K_INITX, R_ZERO},
      '{OP_LDK, R_X1,  K_INITX, R_ZERO},
      '{OP_LDK, R_X2,  K_INITX, R_ZERO},
      '{OP_LDK, R_P00, K_ONE,   R_ZERO},
      '{OP_LDK, R_P01, K_ZERO,  R_ZERO},
      '{OP_LDK, R_P02, K_ZERO,  R_ZERO},
      '{OP_LDK, R_P10, K_ZERO,  R_ZERO},
      '{OP_LDK, R_P11, K_ONE,   R_ZERO},
      '{OP_LDK, R_P12, K_ZERO,  R_ZERO},
      '{OP_LDK, R_P20, K_ZERO,  R_ZERO},
      '{OP_LDK, R_P21, K_ZERO,  R_ZERO},
      '{OP_LDK, R_P22, K_ONE,   R_ZERO},
      '{OP_LDK, R_S,   K_ZERO,  R_ZERO},
      '{OP_END, R_ZERO, R_ZERO, R_ZERO},
      // per-measurement program
      '{OP_LDK, R_ZERO, K_ZERO, R_ZERO},
      '{OP_LDK, R_ONE,  K_ONE,  R_ZERO},
      '{OP_LDK, R_QN,   K_QN,   R_ZERO},
      '{OP_LDK, R_RN,   K_RN,   R_ZERO},
      '{OP_LDK, R_F02,  K_F02,  R_ZERO},
      '{OP_LDK, R_F12,  K_F12,  R_ZERO},
      '{OP_LDK, R_TEN,  K_TEN,  R_ZERO},
      '{OP_LDK, R_RHO,  K_RHO,  R_ZERO},
      '{OP_LDK, R_BETA, K_BETA, R_ZERO},
      '{OP_LDK, R_Z,    K_Z,    R_ZERO},
      '{OP_MUL, R_T0,  R_TEN, R_X1},
      '{OP_ADD, R_XP0, R_X0,  R_T0},
      '{OP_MUL, R_T0,  R_F02, R_X2},
      '{OP_ADD, R_XP0, R_XP0, R_T0},
      '{OP_MUL, R_T0,  R_F12, R_X2},
      '{OP_ADD, R_XP1, R_X1,  R_T0},
      '{OP_SUB, R_E,   R_Z,   R_XP0},
      '{OP_MUL, R_T0,  R_E,   R_E},
      '{OP_MUL, R_T1,  R_RHO, R_S},
      '{OP_ADD, R_T1,  R_T1,  R_T0},
      '{OP_ADD, R_T2,  R_ONE, R_RHO},
      '{OP_DIV, R_T1,  R_T1,  R_T2},
      '{OP_SELS, R_S,  R_T0,  R_T1},
      '{OP_SUB, R_N,   R_S,    R_QN},
      '{OP_MUL, R_T0,  R_BETA, R_RN},
      '{OP_SUB, R_N,   R_N,    R_T0},
      '{OP_MUL, R_T0,   R_TEN,  R_P10},
      '{OP_ADD, R_FP00, R_P00,  R_T0},
      '{OP_MUL, R_T0,   R_F02,  R_P20},
      '{OP_ADD, R_FP00, R_FP00, R_T0},
      '{OP_MUL, R_T0,   R_TEN,  R_P11},
      '{OP_ADD, R_FP01, R_P01,  R_T0},
      '{OP_MUL, R_T0,   R_F02,  R_P21},
      '{OP_ADD, R_FP01, R_FP01, R_T0},
      '{OP_MUL, R_T0,   R_TEN,  R_P12},
      '{OP_ADD, R_FP02, R_P02,  R_T0},
      '{OP_MUL, R_T0,   R_F02,  R_P22},
      '{OP_ADD, R_FP02, R_FP02, R_T0},
      '{OP_MUL, R_T0,   R_F12,  R_P20},
      '{OP_ADD, R_FP10, R_P10,  R_T0},
      '{OP_MUL, R_T0,   R_F12,  R_P21},
      '{OP_ADD, R_FP11, R_P11,  R_T0},
      '{OP_MUL, R_T0,   R_F12,  R_P22},
      '{OP_ADD, R_FP12, R_P12,  R_T0},
      '{OP_MUL, R_T0,  R_FP01, R_TEN},
      '{OP_ADD, R_A00, R_FP00, R_T0},
      '{OP_MUL, R_T0,  R_FP02, R_F02},
      '{OP_ADD, R_A00, R_A00,  R_T0},
      '{OP_MUL, R_T0,  R_FP02, R_F12},
      '{OP_ADD, R_A01, R_FP01, R_T0},
      '{OP_MUL, R_T0,  R_FP11, R_TEN},
      '{OP_ADD, R_A10, R_FP10, R_T0},
      '{OP_MUL, R_T0,  R_FP12, R_F02},
      '{OP_ADD, R_A10, R_A10,  R_T0},
      '{OP_MUL, R_T0,  R_FP12, R_F12},
      '{OP_ADD, R_A11, R_FP11, R_T0},
      '{OP_DIV, R_T0,  R_N,   R_A00},
      '{OP_LAM, R_LAM, R_A00, R_T0},
      '{OP_MUL, R_PP00, R_LAM, R_A00},
      '{OP_MUL, R_PP01, R_LAM, R_A01},
      '{OP_MUL, R_PP10, R_LAM, R_A10},
      '{OP_MUL, R_PP11, R_LAM, R_A11},
      '{OP_ADD, R_PP00, R_PP00, R_QN},
      '{OP_ADD, R_PP11, R_PP11, R_QN},
      '{OP_ADD, R_SD,   R_PP00, R_RN},
      '{OP_DIV, R_K0,   R_PP00, R_SD},
      '{OP_DIV, R_K1,   R_PP10, R_SD},
      '{OP_MUL, R_T0, R_K0,   R_E},
      '{OP_ADD, R_X0, R_XP0,  R_T0},
      '{OP_MUL, R_T0, R_K1,   R_E},
      '{OP_ADD, R_X1, R_XP1,  R_T0},
      '{OP_ADD, R_X2, R_ZERO, R_ZERO},
      '{OP_MUL, R_T0,  R_K0,   R_PP00},
      '{OP_SUB, R_P00, R_PP00, R_T0},
      '{OP_MUL, R_T0,  R_K0,   R_PP01},
      '{OP_SUB, R_P01, R_PP01, R_T0},
      '{OP_ADD, R_P02, R_ZERO, R_ZERO},
      '{OP_MUL, R_T0,  R_K1,   R_PP00},
      '{OP_SUB, R_P10, R_PP10, R_T0},
      '{OP_MUL, R_T0,  R_K1,   R_PP01},
      '{OP_SUB, R_P11, R_PP11, R_T0},
      '{OP_ADD, R_P12, R_ZERO, R_ZERO},
      '{OP_ADD, R_P20, R_ZERO, R_ZERO},
      '{OP_ADD, R_P21, R_ZERO, R_ZERO},
      '{OP_ADD, R_P22, R_QN,   R_ZERO},
      '{OP_MUL, R_T0, R_TEN, R_X1},
      '{OP_ADD, R_T1, R_X0,  R_T0},
      '{OP_MUL, R_T0, R_F02, R_X2},
      '{OP_ADD, R_T1, R_T1,  R_T0},
      '{OP_OUT, 6'd0, R_T1,  R_ZERO},
      '{OP_MUL, R_T0, R_F12, R_X2},
      '{OP_ADD, R_T2, R_X1,  R_T0},
      '{OP_OUT, 6'd1, R_T2,  R_ZERO},
      '{OP_OUT, 6'd2, R_ZERO, R_ZERO},
      '{OP_END, R_ZERO, R_ZERO, R_ZERO}
   };

   function automatic logic [63:0] from_mag(logic neg, logic [63:0] m, logic ovf);
      logic [63:0] r;
      if (ovf || m >= TOP_MAG) begin
         r = neg ? LIM_LO : LIM_HI;
      end else begin
         r = neg ? (64'd0 - m) : m;
      end
      return r;
   endfunction

   function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
      logic signed [64:0] s;
      logic [63:0]        r;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > $signed({LIM_HI[63], LIM_HI})) begin
         r = LIM_HI;
      end else if (s < $signed({LIM_LO[63], LIM_LO})) begin
         r = LIM_LO;
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] ssub(logic [63:0] a, logic [63:0] b);
      logic [63:0] nb;
      nb = ($signed(b) <= $signed(LIM_LO)) ? LIM_HI : (64'd0 - b);
      return sadd(a, nb);
   endfunction

   function automatic logic [31:0] to_port(logic [63:0] v);
      logic [63:0] mag;
      logic [63:0] m;
      logic [63:0] nm;
      logic [31:0] r;
      mag = v[63] ? (64'd0 - v) : v;
      m   = (mag + 64'd32768) >> 16;
      if (v[63]) begin
         if (m > 64'h8000_0000) begin
            m = 64'h8000_0000;
         end
         nm = 64'd0 - m;
         r  = nm[31:0];
      end else begin
         if (m > 64'h7FFF_FFFF) begin
            m = 64'h7FFF_FFFF;
         end
         r = m[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/stkf_mul.sv
// Saturating Q32.32 multiplier built from four sequential 32x32 partial products.
module stkf_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] res
);

   logic         run_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  ma_ff;
   logic [63:0]  mb_ff;
   logic         neg_ff;
   logic [63:0]  pp_ff;
   logic [127:0] acc_ff;
   logic [31:0]  asel;
   logic [31:0]  bsel;
   logic [63:0]  pp_in;
   logic [2:0]   psel;
   logic [127:0] term;
   logic [127:0] rnd;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: begin asel = ma_ff[31:0];  bsel = mb_ff[31:0];  end
         2'd1: begin asel = ma_ff[31:0];  bsel = mb_ff[63:32]; end
         2'd2: begin asel = ma_ff[63:32]; bsel = mb_ff[31:0];  end
         default: begin asel = ma_ff[63:32]; bsel = mb_ff[63:32]; end
      endcase
      pp_in = {32'd0, asel} * {32'd0, bsel};
      psel  = cnt_ff - 3'd1;
      unique case (psel[1:0])
         2'd0: term = {64'd0, pp_ff};
         2'd1, 2'd2: term = {32'd0, pp_ff, 32'd0};
         default: term = {pp_ff, 64'd0};
      endcase
      rnd  = acc_ff + 128'h8000_0000;
      done = run_ff && (cnt_ff == 3'd5);
      res  = stkf_pkg::from_mag(neg_ff, rnd[95:32], |rnd[127:96]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= 3'd0;
      end else if (start) begin
         run_ff <= 1'b1;
         cnt_ff <= 3'd0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 3'd1;
         if (cnt_ff == 3'd5) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= a[63] ? (64'd0 - a) : a;
         mb_ff  <= b[63] ? (64'd0 - b) : b;
         neg_ff <= a[63] ^ b[63];
         acc_ff <= '0;
      end else if (run_ff) begin
         pp_ff <= pp_in;
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_ff <= acc_ff + term;
         end
      end
   end

endmodule

### rtl/stkf_div.sv
// Saturating Q32.32 divider, restoring, one quotient bit per cycle.
module stkf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] res
);

   logic         run_ff;
   logic         fin_ff;
   logic [6:0]   cnt_ff;
   logic [127:0] num_ff;
   logic [64:0]  r_ff;
   logic [63:0]  q_ff;
   logic         ovf_ff;
   logic         neg_ff;
   logic [63:0]  ub_ff;
   logic [63:0]  res_ff;
   logic [63:0]  ua;
   logic [63:0]  ub;
   logic [64:0]  rs;
   logic [63:0]  qs;
   logic         ovf_in;

   always_comb begin
      ua     = a[63] ? (64'd0 - a) : a;
      ub     = b[63] ? (64'd0 - b) : b;
      rs     = {r_ff[63:0], num_ff[127]};
      qs     = {q_ff[62:0], 1'b0};
      ovf_in = ovf_ff | q_ff[63];
      if (rs >= {1'b0, ub_ff}) begin
         rs    = rs - {1'b0, ub_ff};
         qs[0] = 1'b1;
      end
      done = fin_ff;
      res  = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         cnt_ff <= 7'd0;
      end else begin
         fin_ff <= 1'b0;
         if (start) begin
            cnt_ff <= 7'd0;
            if (ub == 64'd0) begin
               fin_ff <= 1'b1;
            end else begin
               run_ff <= 1'b1;
            end
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {32'd0, ua, 32'd0};
         r_ff   <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
         neg_ff <= a[63] ^ b[63];
         ub_ff  <= ub;
         if (a == 64'd0) begin
            res_ff <= 64'd0;
         end else begin
            res_ff <= a[63] ? stkf_pkg::LIM_LO : stkf_pkg::LIM_HI;
         end
      end else if (run_ff) begin
         num_ff <= {num_ff[126:0], 1'b0};
         r_ff   <= rs;
         q_ff   <= qs;
         ovf_ff <= ovf_in;
         if (cnt_ff == 7'd127) begin
            res_ff <= stkf_pkg::from_mag(neg_ff, qs, ovf_in);
         end
      end
   end

endmodule

### rtl/stkf_dp.sv
// Datapath: register file, saturating add/sub, shared multiplier and divider, result registers.
module stkf_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  stkf_pkg::cmd_type    cmd,
   output stkf_pkg::status_type sts,
   input  logic [31:0]          meas,
   input  logic                 csr_we,
   input  logic                 csr_idx,
   input  logic [23:0]          csr_wdata,
   output logic [31:0]          pred_position,
   output logic [31:0]          pred_velocity,
   output logic [31:0]          pred_accel
);

   logic [63:0]         rf [stkf_pkg::NREG];
   stkf_pkg::instr_type ins_ff;
   logic [63:0]         opa_ff;
   logic [63:0]         opb_ff;
   logic                ex_ff;
   logic                st_ff;
   logic                first_ff;
   logic [63:0]         z_ff;
   logic [16:0]         forget_ff;
   logic [23:0]         weak_ff;
   logic [31:0]         out_ff [3];
   logic                unit_start;
   logic                mul_done;
   logic                div_done;
   logic [63:0]         mul_res;
   logic [63:0]         div_res;
   logic [63:0]         result;
   logic                done;
   logic                wr;

   stkf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (unit_start && ins_ff.op == stkf_pkg::OP_MUL),
      .a     (opa_ff),
      .b     (opb_ff),
      .done  (mul_done),
      .res   (mul_res)
   );

   stkf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (unit_start && ins_ff.op == stkf_pkg::OP_DIV),
      .a     (opa_ff),
      .b     (opb_ff),
      .done  (div_done),
      .res   (div_res)
   );

   always_comb begin
      unit_start = ex_ff && st_ff;
      result     = 64'd0;
      done       = ex_ff;
      unique case (ins_ff.op)
         stkf_pkg::OP_LDK: begin
            unique case (ins_ff.a)
               stkf_pkg::K_ONE:   result = stkf_pkg::ONE_Q;
               stkf_pkg::K_QN:    result = stkf_pkg::Q_NOISE;
               stkf_pkg::K_RN:    result = stkf_pkg::R_NOISE;
               stkf_pkg::K_F02:   result = stkf_pkg::F_02;
               stkf_pkg::K_F12:   result = stkf_pkg::F_12;
               stkf_pkg::K_TEN:   result = stkf_pkg::TEN_Q;
               stkf_pkg::K_INITX: result = stkf_pkg::INIT_X;
               stkf_pkg::K_RHO:   result = {31'd0, forget_ff, 16'd0};
               stkf_pkg::K_BETA:  result = {24'd0, weak_ff, 16'd0};
               stkf_pkg::K_Z:     result = z_ff;
               default:           result = 64'd0;
            endcase
         end
         stkf_pkg::OP_ADD:  result = stkf_pkg::sadd(opa_ff, opb_ff);
         stkf_pkg::OP_SUB:  result = stkf_pkg::ssub(opa_ff, opb_ff);
         stkf_pkg::OP_MUL: begin
            result = mul_res;
            done   = ex_ff && mul_done;
         end
         stkf_pkg::OP_DIV: begin
            result = div_res;
            done   = ex_ff && div_done;
         end
         stkf_pkg::OP_SELS: result = first_ff ? opa_ff : opb_ff;
         stkf_pkg::OP_LAM: begin
            if ($signed(opa_ff) > 0 && $signed(opb_ff) >= $signed(stkf_pkg::ONE_Q)) begin
               result = opb_ff;
            end else begin
               result = stkf_pkg::ONE_Q;
            end
         end
         default: result = 64'd0;
      endcase
      wr       = done && ins_ff.op != stkf_pkg::OP_OUT && ins_ff.op != stkf_pkg::OP_END;
      sts.done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_ff     <= 1'b0;
         st_ff     <= 1'b0;
         first_ff  <= 1'b1;
         forget_ff <= stkf_pkg::FORGET_RST;
         weak_ff   <= stkf_pkg::WEAK_RST;
      end else begin
         if (cmd.go) begin
            ex_ff <= 1'b1;
            st_ff <= 1'b1;
         end else begin
            st_ff <= 1'b0;
            if (done) begin
               ex_ff <= 1'b0;
            end
         end
         if (done && ins_ff.op == stkf_pkg::OP_SELS) begin
            first_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_idx)
               stkf_pkg::CSR_FORGET: forget_ff <= csr_wdata[16:0];
               stkf_pkg::CSR_WEAK:   weak_ff   <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go) begin
         ins_ff <= cmd.ins;
         opa_ff <= rf[cmd.ins.a];
         opb_ff <= rf[cmd.ins.b];
      end
      if (wr) begin
         rf[ins_ff.dst] <= result;
      end
      if (cmd.load) begin
         z_ff <= {{16{meas[31]}}, meas, 16'd0};
      end
      if (done && ins_ff.op == stkf_pkg::OP_OUT) begin
         out_ff[ins_ff.dst[1:0]] <= stkf_pkg::to_port(opa_ff);
      end
   end

   assign pred_position = out_ff[0];
   assign pred_velocity = out_ff[1];
   assign pred_accel    = out_ff[2];

endmodule

### rtl/stkf_ctrl.sv
// Sequencer: microprogram counter, instruction issue and stream handshakes.
module stkf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output stkf_pkg::cmd_type    cmd,
   input  stkf_pkg::status_type sts
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [stkf_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                     item_ff, item_in;
   logic                     rv_ff, rv_in;
   stkf_pkg::instr_type      ins;

   always_comb begin
      ins        = stkf_pkg::PROG[pc_ff];
      state_in   = state_ff;
      pc_in      = pc_ff;
      item_in    = item_ff;
      rv_in      = rv_ff;
      cmd.go     = 1'b0;
      cmd.load   = 1'b0;
      cmd.ins    = ins;
      req_tready = (state_ff == ST_IDLE);
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               pc_in    = stkf_pkg::PC_W'(stkf_pkg::ITEM_START);
               item_in  = 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (ins.op == stkf_pkg::OP_END) begin
               if (item_ff) begin
                  rv_in = 1'b1;
               end
               item_in  = 1'b0;
               state_in = ST_IDLE;
            end else if (!(ins.op == stkf_pkg::OP_OUT && rv_ff)) begin
               cmd.go   = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sts.done) begin
               pc_in    = pc_ff + 1'b1;
               state_in = ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_tvalid = rv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ISSUE;
         pc_ff    <= '0;
         item_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         item_ff  <= item_in;
         rv_ff    <= rv_in;
      end
   end

endmodule

### rtl/strong_tracking_kalman_filter_core.sv
// Strong tracking Kalman filter (Singer model) top level.
//
// Input stream req_*: one beat carries one measured position (signed Q16.16).
// Output stream rsp_*: one beat per input beat with the one-step-ahead predicted
// position, velocity and acceleration (signed Q16.16, rounded, saturated).
// csr_*: write-only registers, index 0 forgetting factor (Q1.16, 17 bits),
// index 1 weakening factor (Q8.16, 24 bits); write only while idle.
// Items are processed one at a time by a microprogrammed sequencer over a
// register file, a four-step 32x32 multiplier and a bit-serial divider.
// Most of the time from input beat to rsp_tvalid goes to the four divisions;
// 34 multiplications and 56 simple operations take the rest. Reset loads the
// filter state from a short startup program, during which req_tready stays low.
// A result is held in rsp_tdata until taken. A new beat is accepted while it
// waits; that beat stalls at its output step until the previous result leaves.
module strong_tracking_kalman_filter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] position_meas
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] pred_position, [63:32] pred_velocity, [95:64] pred_accel
   input  logic        csr_we,
   input  logic        csr_idx,
   input  logic [23:0] csr_wdata
);

   stkf_pkg::cmd_type    cmd;
   stkf_pkg::status_type sts;
   logic [31:0]          pos;
   logic [31:0]          vel;
   logic [31:0]          acc;

   stkf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   stkf_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .meas          (req_tdata),
      .csr_we        (csr_we),
      .csr_idx       (csr_idx),
      .csr_wdata     (csr_wdata),
      .pred_position (pos),
      .pred_velocity (vel),
      .pred_accel    (acc)
   );

   assign rsp_tdata = {acc, vel, pos};

endmodule
